[hw/rtl/gds_pkg.sv]
`timescale 1ns / 1ps

package gds_pkg;

  // Geometry and number format
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 4096;
  localparam int FRAC_BITS  = 24;

  // Field and register widths
  localparam int VAL_W      = 32;
  localparam int GW_W       = 9;
  localparam int GH_W       = 13;
  localparam int GAIN_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Raster counters and pending count (pending peaks at one row plus two cells)
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int PEND_W = $clog2(MAX_WIDTH + 3);
  localparam int OFS_W  = PEND_W + 1;

  // Line memory: holds two rows plus a few cells of history, rounded up to a power of two
  localparam int LINE_AW    = $clog2(2 * MAX_WIDTH + 9);
  localparam int LINE_DEPTH = 1 << LINE_AW;

  // Stencil taps: centre first, then four orthogonal, then four diagonal
  localparam int TAP_W = 4;
  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(8);

  // Stencil weights, 24 fraction bits
  localparam int CONST_FRAC = 24;
  localparam int INV_W      = 23;
  localparam int FOUR_W     = 27;
  localparam logic [INV_W-1:0]  INV_TWO_SQRT2_Q24       = INV_W'(5931642);
  localparam logic [FOUR_W-1:0] FOUR_PLUS_TWO_SQRT2_Q24 = FOUR_W'(114561997);

  // Arithmetic widths
  localparam int ACC_W   = VAL_W + 2;
  localparam int DPROD_W = ACC_W + INV_W;
  localparam int CPROD_W = VAL_W + FOUR_W;
  localparam int T_W     = CPROD_W + 2;
  localparam int INNER_W = T_W - CONST_FRAC;
  localparam int GP_W    = INNER_W + GAIN_W + 1;
  localparam int DELTA_W = GP_W + 1 - FRAC_BITS;
  localparam int RES_W   = DELTA_W + 1;

  // Reset values of the geometry registers
  localparam int RST_GRID_WIDTH  = 256;
  localparam int RST_GRID_HEIGHT = 256;

  // Request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_DRAIN  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION_GAIN = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_MUL,
    ST_TERM,
    ST_GAIN,
    ST_OUT
  } st_t;

  typedef enum logic [1:0] {
    TK_CENTER,
    TK_ORTHO,
    TK_DIAG
  } tap_kind_t;

  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } tap_geom_t;

  // Controls from the sequencer to the arithmetic
  typedef struct packed {
    logic      clear;
    logic      acc_en;
    logic      acc_use;
    tap_kind_t acc_kind;
    logic      mul_en;
    logic      term_en;
    logic      gain_en;
  } arith_ctl_t;

  // Neighbour direction of each tap
  function automatic tap_geom_t tap_geom(input logic [TAP_W-1:0] tap);
    tap_geom_t g;
    begin
      g = '0;
      case (tap)
        TAP_W'(1): g.up = 1'b1;
        TAP_W'(2): g.dn = 1'b1;
        TAP_W'(3): g.lf = 1'b1;
        TAP_W'(4): g.rt = 1'b1;
        TAP_W'(5): begin
          g.up = 1'b1;
          g.lf = 1'b1;
        end
        TAP_W'(6): begin
          g.up = 1'b1;
          g.rt = 1'b1;
        end
        TAP_W'(7): begin
          g.dn = 1'b1;
          g.lf = 1'b1;
        end
        TAP_W'(8): begin
          g.dn = 1'b1;
          g.rt = 1'b1;
        end
        default: g = '0;
      endcase
      return g;
    end
  endfunction

endpackage

[hw/rtl/gds_ram.sv]
`timescale 1ns / 1ps

module gds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/gds_arith.sv]
`timescale 1ns / 1ps

module gds_arith import gds_pkg::*; (
  input  logic              clk,
  input  arith_ctl_t        ctl,
  input  logic [VAL_W-1:0]  rd_data,
  input  logic [GAIN_W-1:0] gain,
  output logic [VAL_W-1:0]  result
);

  logic [ACC_W-1:0]          ortho_r;
  logic [ACC_W-1:0]          diag_r;
  logic [VAL_W-1:0]          center_r;
  logic [DPROD_W-1:0]        dprod_r;
  logic [CPROD_W-1:0]        cprod_r;
  logic [T_W-1:0]            term_r;
  logic [T_W-1:0]            term_sum;
  logic signed [INNER_W-1:0] inner;
  logic signed [GAIN_W:0]    gain_s;
  logic signed [GP_W-1:0]    gp_r;
  logic signed [GP_W:0]      gp_rnd;
  logic signed [DELTA_W-1:0] delta;
  logic signed [RES_W-1:0]   res;

  // Tap accumulation as read data lands
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      ortho_r  <= '0;
      diag_r   <= '0;
      center_r <= '0;
    end else if (ctl.acc_en && ctl.acc_use) begin
      case (ctl.acc_kind)
        TK_CENTER: center_r <= rd_data;
        TK_ORTHO:  ortho_r  <= ortho_r + ACC_W'(rd_data);
        TK_DIAG:   diag_r   <= diag_r + ACC_W'(rd_data);
        default:   ;
      endcase
    end
  end

  // Weighted sums: ortho*2^24 + diag/(2sqrt2) - (4+2sqrt2)*centre, rounding half added
  assign term_sum = T_W'({ortho_r, {CONST_FRAC{1'b0}}}) + T_W'(dprod_r)
                  + T_W'(1 << (CONST_FRAC - 1)) - T_W'(cprod_r);

  assign inner  = term_r[T_W-1:CONST_FRAC];
  assign gain_s = {1'b0, gain};

  // Gain product rounded back to sample units, added to the centre
  assign gp_rnd = (GP_W + 1)'(gp_r) + (GP_W + 1)'(1 << (FRAC_BITS - 1));
  assign delta  = gp_rnd[GP_W:FRAC_BITS];
  assign res    = RES_W'(delta) + RES_W'(center_r);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      dprod_r <= DPROD_W'(diag_r) * DPROD_W'(INV_TWO_SQRT2_Q24);
      cprod_r <= CPROD_W'(center_r) * CPROD_W'(FOUR_PLUS_TWO_SQRT2_Q24);
    end
    if (ctl.term_en) begin
      term_r <= term_sum;
    end
    if (ctl.gain_en) begin
      gp_r <= inner * gain_s;
    end
  end

  // Saturate to the sample range
  always_comb begin
    if (res[RES_W-1]) begin
      result = '0;
    end else if (|res[RES_W-2:VAL_W]) begin
      result = '1;
    end else begin
      result = res[VAL_W-1:0];
    end
  end

endmodule

[hw/rtl/grid_diffusion_stencil.sv]
`timescale 1ns / 1ps

// Channel  Handshake             Payload
// in       in_valid / in_ready   in_req_type, in_cell_value
// out      out_valid / out_ready out_new_value, out_last_of_frame
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A sample that releases no result is only written to the line memory. One that releases a
// result, or a drain tick with one pending, is accepted, makes 9 reads of the single read
// port of the line memory (one per stencil tap), then multiplies, sums, gains and outputs.
// rst_n is synchronous and active low; it clears counters and control, not the line memory.
// The result waits in an output register; the next item is taken meanwhile, and only the
// final step of the following result waits for that register to empty.

module grid_diffusion_stencil import gds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [VAL_W-1:0]      in_cell_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VAL_W-1:0]      out_new_value,
  output logic                  out_last_of_frame,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  st_t                  state_r, state_nxt;
  logic [GW_W-1:0]      gw_r;
  logic [GH_W-1:0]      gh_r;
  logic [GAIN_W-1:0]    gain_r;
  logic [COL_W-1:0]     col_r, ocol_r;
  logic [ROW_W-1:0]     row_r, orow_r;
  logic [PEND_W-1:0]    pend_r;
  logic [LINE_AW-1:0]   wr_ptr_r;
  logic [TAP_W-1:0]     tap_r;
  logic                 rq_vld_r;
  logic                 rq_use_r;
  tap_kind_t            rq_kind_r;
  logic                 out_valid_r;
  logic [VAL_W-1:0]     out_value_r;
  logic                 out_last_r;

  logic                 in_acc, smp_acc, emit_smp, start, out_free, fin, rd_en;
  logic                 col_wrap, row_wrap, ocol_wrap, orow_wrap;
  arith_ctl_t           ctl;
  tap_geom_t            tg;
  tap_kind_t            tap_kind;
  logic                 in_grid, tap_use;
  logic signed [OFS_W-1:0] ofs, w_ofs, pend_s;
  logic [LINE_AW-1:0]   base, raddr;
  logic [VAL_W-1:0]     rd_data, arith_res;
  logic [GW_W-1:0]      gw_val;
  logic [GH_W-1:0]      gh_val;

  // Handshake and decisions
  assign in_acc   = in_valid && in_ready;
  assign smp_acc  = in_acc && (in_req_type == REQ_SAMPLE);
  assign emit_smp = (PEND_W + 1)'(pend_r) > (PEND_W + 1)'(gw_r);
  assign start    = in_acc && (((in_req_type == REQ_DRAIN) && (pend_r != '0)) ||
                               ((in_req_type == REQ_SAMPLE) && emit_smp));
  assign out_free = !out_valid_r || out_ready;
  assign fin      = (state_r == ST_OUT) && out_free;

  // Raster wrap conditions
  assign col_wrap  = (GW_W'(col_r) + GW_W'(1)) >= gw_r;
  assign row_wrap  = (GH_W'(row_r) + GH_W'(1)) >= gh_r;
  assign ocol_wrap = (GW_W'(ocol_r) + GW_W'(1)) >= gw_r;
  assign orow_wrap = (GH_W'(orow_r) + GH_W'(1)) >= gh_r;

  // Tap address and mask: offset from the centre cell in the line
  assign tg     = tap_geom(tap_r);
  assign w_ofs  = OFS_W'(gw_r);
  assign pend_s = OFS_W'(pend_r);

  always_comb begin
    ofs = '0;
    if (tg.up) ofs = ofs - w_ofs;
    if (tg.dn) ofs = ofs + w_ofs;
    if (tg.lf) ofs = ofs - OFS_W'(1);
    if (tg.rt) ofs = ofs + OFS_W'(1);
  end

  assign in_grid = !(tg.up && (orow_r == '0)) && !(tg.dn && orow_wrap) &&
                   !(tg.lf && (ocol_r == '0)) && !(tg.rt && ocol_wrap);
  // neighbours not yet arrived count as zero
  assign tap_use = in_grid && (ofs < pend_s);

  always_comb begin
    if (!(tg.up || tg.dn || tg.lf || tg.rt)) begin
      tap_kind = TK_CENTER;
    end else if ((tg.up || tg.dn) != (tg.lf || tg.rt)) begin
      tap_kind = TK_ORTHO;
    end else begin
      tap_kind = TK_DIAG;
    end
  end

  assign base  = wr_ptr_r - LINE_AW'(pend_r);
  assign raddr = base + LINE_AW'(ofs);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    rd_en        = 1'b0;
    ctl          = '0;
    ctl.clear    = start;
    ctl.acc_en   = rq_vld_r;
    ctl.acc_use  = rq_use_r;
    ctl.acc_kind = rq_kind_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (start) state_nxt = ST_READ;
      end
      ST_READ: begin
        rd_en = 1'b1;
        if (tap_r == TAP_LAST) state_nxt = ST_SUM;
      end
      ST_SUM: state_nxt = ST_MUL;
      ST_MUL: begin
        ctl.mul_en = 1'b1;
        state_nxt  = ST_TERM;
      end
      ST_TERM: begin
        ctl.term_en = 1'b1;
        state_nxt   = ST_GAIN;
      end
      ST_GAIN: begin
        ctl.gain_en = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Clamped geometry values
  always_comb begin
    gw_val = cfg_data[GW_W-1:0];
    if (gw_val == '0) gw_val = GW_W'(1);
    else if (gw_val > GW_W'(MAX_WIDTH)) gw_val = GW_W'(MAX_WIDTH);
    gh_val = cfg_data[GH_W-1:0];
    if (gh_val == '0) gh_val = GH_W'(1);
    else if (gh_val > GH_W'(MAX_HEIGHT)) gh_val = GH_W'(MAX_HEIGHT);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gw_r        <= GW_W'(RST_GRID_WIDTH);
      gh_r        <= GH_W'(RST_GRID_HEIGHT);
      gain_r      <= '0;
      col_r       <= '0;
      row_r       <= '0;
      ocol_r      <= '0;
      orow_r      <= '0;
      pend_r      <= '0;
      wr_ptr_r    <= '0;
      tap_r       <= '0;
      rq_vld_r    <= 1'b0;
      rq_use_r    <= 1'b0;
      rq_kind_r   <= TK_CENTER;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // sample written into the line; input raster position advances
      if (smp_acc) begin
        wr_ptr_r <= wr_ptr_r + LINE_AW'(1);
        if (col_wrap) begin
          col_r <= '0;
          row_r <= row_wrap ? '0 : row_r + ROW_W'(1);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end

      if (smp_acc) begin
        pend_r <= pend_r + PEND_W'(1);
      end else if (fin) begin
        pend_r <= pend_r - PEND_W'(1);
      end

      // result position advances as each result enters the output register
      if (fin) begin
        if (ocol_wrap) begin
          ocol_r <= '0;
          orow_r <= orow_wrap ? '0 : orow_r + ROW_W'(1);
        end else begin
          ocol_r <= ocol_r + COL_W'(1);
        end
      end

      // tap counter and read tags
      if (start) begin
        tap_r <= '0;
      end else if (rd_en) begin
        tap_r <= tap_r + TAP_W'(1);
      end
      rq_vld_r  <= rd_en;
      rq_use_r  <= tap_use;
      rq_kind_r <= tap_kind;

      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      // register writes; geometry writes restart the frame
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_GRID_WIDTH, REG_GRID_HEIGHT: begin
            if (cfg_index == REG_GRID_WIDTH) gw_r <= gw_val;
            else gh_r <= gh_val;
            col_r  <= '0;
            row_r  <= '0;
            ocol_r <= '0;
            orow_r <= '0;
            pend_r <= '0;
          end
          REG_DIFFUSION_GAIN: gain_r <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fin) begin
      out_value_r <= arith_res;
      out_last_r  <= orow_wrap && ocol_wrap;
    end
  end

  gds_ram #(
    .WIDTH (VAL_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (smp_acc),
    .waddr (wr_ptr_r),
    .wdata (in_cell_value),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rd_data)
  );

  gds_arith u_arith (
    .clk     (clk),
    .ctl     (ctl),
    .rd_data (rd_data),
    .gain    (gain_r),
    .result  (arith_res)
  );

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_new_value     = out_value_r;
  assign out_last_of_frame = out_last_r;

  // Pending results never exceed one row plus one cell between items
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ((PEND_W + 1)'(pend_r) <= (PEND_W + 1)'(gw_r) + (PEND_W + 1)'(1)))
    else $error("pending count above one row plus one cell");

  // A result is only computed while one is pending
  a_read_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (pend_r != '0))
    else $error("tap reads with nothing pending");

  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (tap_r <= TAP_LAST))
    else $error("tap counter ran past the last tap");

  // The output register fills only from the final step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result appeared outside the final step");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import gds_pkg::*;

  // Predictor delay line: two full rows plus the 3x3 window
  localparam int DELAY_LEN = 2 * MAX_WIDTH + 9;
  // Stencil weights with 24 fraction bits
  localparam longint W_ORTHO  = 64'sd16777216;
  localparam longint W_DIAG   = 64'sd5931642;
  localparam longint W_CENTRE = 64'sd114561997;
  localparam longint VAL_TOP  = 64'sd4294967295;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RAND_ITEMS    = 650;
  localparam int CALM_AFTER    = 560;

  typedef struct packed {
    logic             req;
    logic [VAL_W-1:0] val;
  } stim_t;

  typedef struct packed {
    logic [VAL_W-1:0] nv;
    logic             last;
  } cell_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_req_type = REQ_SAMPLE;
  logic [VAL_W-1:0]      in_cell_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VAL_W-1:0]      out_new_value;
  logic                  out_last_of_frame;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  grid_diffusion_stencil u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_cell_value     (in_cell_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_new_value     (out_new_value),
    .out_last_of_frame (out_last_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [VAL_W-1:0] line_mem [DELAY_LEN];
  int               wr_ptr;
  int               pend;
  int               out_row;
  int               out_col;
  int               gw;
  int               gh;
  longint           gain;

  stim_t     item_q[$];
  cell_res_t diffused_q[$];

  int  n_items;
  int  n_results;
  int  n_cfg;
  int  n_phases;
  int  errors;
  int  cycles;
  int  in_gap;
  int  ready_gap;
  bit  calm;

  // Compute the result of the oldest pending cell and queue it
  function automatic void release_cell();
    int     base;
    int     r;
    int     c;
    int     d;
    longint ortho;
    longint diag;
    longint ctr;
    longint nb;
    longint t;
    longint inner;
    longint res;
    cell_res_t e;
    base  = wr_ptr - pend;
    ortho = 0;
    diag  = 0;
    ctr   = longint'({32'd0, line_mem[(base + DELAY_LEN) % DELAY_LEN]});
    for (int dr = -1; dr <= 1; dr++) begin
      r = out_row + dr;
      if (r >= 0 && r < gh) begin
        for (int dc = -1; dc <= 1; dc++) begin
          c = out_col + dc;
          d = dr * gw + dc;
          if (!(dr == 0 && dc == 0) && c >= 0 && c < gw && d < pend) begin
            nb = longint'({32'd0, line_mem[(base + d + DELAY_LEN) % DELAY_LEN]});
            if (dr == 0 || dc == 0) ortho += nb;
            else diag += nb;
          end
        end
      end
    end
    t     = ortho * W_ORTHO + diag * W_DIAG - ctr * W_CENTRE;
    inner = (t + 64'sd8388608) >>> 24;
    res   = ctr + ((inner * gain + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    if (res < 0) res = 0;
    if (res > VAL_TOP) res = VAL_TOP;
    e.nv   = res[VAL_W-1:0];
    e.last = (out_row == gh - 1) && (out_col == gw - 1);
    diffused_q.push_back(e);
    out_col++;
    if (out_col >= gw) begin
      out_col = 0;
      out_row++;
      if (out_row >= gh) out_row = 0;
    end
    pend--;
  endfunction

  // One accepted item: a sample enters the line and may release a cell, a drain flushes one pending cell
  function automatic void take_item(logic req, logic [VAL_W-1:0] val);
    if (req == REQ_DRAIN) begin
      if (pend != 0) release_cell();
    end else begin
      line_mem[wr_ptr] = val;
      wr_ptr = (wr_ptr + 1) % DELAY_LEN;
      pend++;
      if (pend > gw + 1) release_cell();
    end
  endfunction

  // Register write; geometry writes restart the frame
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int v;
    case (idx)
      REG_GRID_WIDTH: begin
        v = int'(data[GW_W-1:0]);
        if (v < 1) v = 1;
        if (v > MAX_WIDTH) v = MAX_WIDTH;
        gw = v;
        pend = 0;
        out_row = 0;
        out_col = 0;
      end
      REG_GRID_HEIGHT: begin
        v = int'(data[GH_W-1:0]);
        if (v < 1) v = 1;
        if (v > MAX_HEIGHT) v = MAX_HEIGHT;
        gh = v;
        pend = 0;
        out_row = 0;
        out_col = 0;
      end
      REG_DIFFUSION_GAIN: gain = longint'({40'd0, data[GAIN_W-1:0]});
      default: ;
    endcase
  endfunction

  // Concentration mix: extremes, top-byte-only steps, near-saturation and full random
  function automatic logic [VAL_W-1:0] rand_conc();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 6))
      0: v = '0;
      1: v = '1;
      2: v = VAL_W'($urandom_range(0, 255)) << 24;
      3: v = 32'hFF00_0000 | VAL_W'($urandom_range(0, 32'h00FF_FFFF));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Item driver
  always @(posedge clk) begin : drive_items
    stim_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        take_item(in_req_type, in_cell_value);
        n_items++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (item_q.size() != 0) begin
          nxt = item_q.pop_front();
          in_valid      <= 1'b1;
          in_req_type   <= nxt.req;
          in_cell_value <= nxt.val;
          if (!calm && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin : watch_results
    cell_res_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (diffused_q.size() == 0) begin
          $error("result with nothing expected: new_value %h last_of_frame %b",
                 out_new_value, out_last_of_frame);
          errors++;
        end else begin
          e = diffused_q.pop_front();
          if (out_new_value !== e.nv) begin
            $error("new_value: expected %h, got %h", e.nv, out_new_value);
            errors++;
          end
          if (out_last_of_frame !== e.last) begin
            $error("last_of_frame: expected %b, got %b", e.last, out_last_of_frame);
            errors++;
          end
        end
      end
      if (ready_gap != 0) begin
        ready_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) ready_gap = $urandom_range(1, 7);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("grid_diffusion_stencil regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  // Wait until every item is in and every result is out, then let the block go idle
  task automatic settle();
    while (item_q.size() != 0 || in_valid || diffused_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus
  initial begin : run
    int               n;
    int               n_rand;
    int               flush;
    logic [GW_W-1:0]  w9;
    logic [GH_W-1:0]  h13;
    logic [GAIN_W-1:0] g24;
    gw = RST_GRID_WIDTH;
    gh = RST_GRID_HEIGHT;
    gain = 0;
    wr_ptr = 0;
    pend = 0;
    out_row = 0;
    out_col = 0;
    for (int i = 0; i < DELAY_LEN; i++) line_mem[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry and zero gain: results equal the centre; drain mid-frame,
    // then a drain with nothing pending
    item_q.push_back({REQ_SAMPLE, 32'h0000_0000});
    item_q.push_back({REQ_SAMPLE, 32'hFFFF_FFFF});
    item_q.push_back({REQ_SAMPLE, 32'h1234_5678});
    repeat (4) item_q.push_back({REQ_DRAIN, 32'hA5A5_A5A5});
    n_phases++;
    settle();

    // 3x3 checkerboard at full gain: saturates both low and high, full flush
    write_reg(REG_GRID_WIDTH, 24'd3);
    write_reg(REG_GRID_HEIGHT, 24'd3);
    write_reg(REG_DIFFUSION_GAIN, 24'hFF_FFFF);
    for (int i = 0; i < 9; i++) item_q.push_back({REQ_SAMPLE, (i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0});
    repeat (5) item_q.push_back({REQ_DRAIN, 32'h0});
    n_phases++;
    settle();

    // Zero geometry acts as 1x1; unused index is ignored
    write_reg(REG_GRID_WIDTH, 24'h00_0000);
    write_reg(REG_GRID_HEIGHT, 24'hFF_E000);
    write_reg(REG_UNUSED, 24'h5A_5A5A);
    write_reg(REG_DIFFUSION_GAIN, 24'h00_0001);
    item_q.push_back({REQ_SAMPLE, 32'h8000_0000});
    item_q.push_back({REQ_DRAIN, 32'hFFFF_FFFF});
    n_phases++;
    settle();

    // Drains before neighbours arrive, then a geometry write drops what is pending
    write_reg(REG_GRID_WIDTH, 24'd4);
    write_reg(REG_GRID_HEIGHT, 24'd2);
    write_reg(REG_DIFFUSION_GAIN, 24'h40_0000);
    item_q.push_back({REQ_SAMPLE, 32'h0100_0000});
    item_q.push_back({REQ_SAMPLE, 32'h0200_0000});
    item_q.push_back({REQ_DRAIN, 32'h0});
    item_q.push_back({REQ_DRAIN, 32'h0});
    item_q.push_back({REQ_SAMPLE, 32'h0300_0000});
    item_q.push_back({REQ_SAMPLE, 32'h0400_0000});
    item_q.push_back({REQ_SAMPLE, 32'h0500_0000});
    n_phases++;
    settle();
    write_reg(REG_GRID_HEIGHT, 24'd2);

    // Widest rows with clamped width and height, long partial frame
    n_rand = 0;
    write_reg(REG_GRID_WIDTH, 24'h00_01FF);
    write_reg(REG_GRID_HEIGHT, 24'h00_1FFF);
    write_reg(REG_DIFFUSION_GAIN, 24'($urandom));
    for (int i = 0; i < 300; i++) begin
      if ($urandom_range(0, 29) == 0) item_q.push_back({REQ_DRAIN, VAL_W'($urandom)});
      item_q.push_back({REQ_SAMPLE, rand_conc()});
    end
    repeat (20) item_q.push_back({REQ_DRAIN, VAL_W'($urandom)});
    n_rand += item_q.size();
    n_phases++;
    settle();

    // Small grids: mostly whole frames with a flush, some broken off or noisy
    while (n_rand < RAND_ITEMS) begin
      if (n_rand >= CALM_AFTER) calm = 1'b1;
      case ($urandom_range(0, 9))
        0: w9 = '0;
        1: w9 = 9'd1;
        2: w9 = 9'd2;
        3: w9 = 9'd3;
        4: w9 = 9'($urandom_range(17, 40));
        default: w9 = 9'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 7))
        0: h13 = '0;
        1: h13 = 13'd1;
        default: h13 = 13'($urandom_range(2, 5));
      endcase
      case ($urandom_range(0, 5))
        0: g24 = '0;
        1: g24 = '1;
        2: g24 = 24'($urandom_range(0, 4096));
        default: g24 = 24'($urandom);
      endcase
      write_reg(REG_GRID_WIDTH, {15'($urandom), w9});
      write_reg(REG_GRID_HEIGHT, {11'($urandom), h13});
      write_reg(REG_DIFFUSION_GAIN, g24);
      if ($urandom_range(0, 5) == 0) write_reg(REG_UNUSED, 24'($urandom));
      n = gw * gh * $urandom_range(1, 2);
      if (n > 120) n = 120;
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) item_q.push_back({REQ_DRAIN, VAL_W'($urandom)});
        item_q.push_back({REQ_SAMPLE, rand_conc()});
      end
      if ($urandom_range(0, 4) != 0) begin
        flush = gw + 1 + $urandom_range(0, 2);
        repeat (flush) item_q.push_back({REQ_DRAIN, VAL_W'($urandom)});
      end
      n_rand += item_q.size();
      n_phases++;
      settle();
    end

    if (diffused_q.size() != 0) begin
      $error("%0d expected results never arrived", diffused_q.size());
      errors++;
    end
    $display("covered %0d items and %0d results over %0d phases, %0d register writes",
             n_items, n_results, n_phases, n_cfg);
    $display("geometry from 1x1 to 256 wide, gain from zero to full scale, %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("grid_diffusion_stencil regression: pass");
    end else begin
      $display("grid_diffusion_stencil regression: fail");
    end
    $finish;
  end

endmodule

[grid_diffusion_stencil.f]
hw/rtl/gds_pkg.sv
hw/rtl/gds_ram.sv
hw/rtl/gds_arith.sv
hw/rtl/grid_diffusion_stencil.sv
tb/tb.sv
